/* hdl/ieval_pkg.sv */
// shared types and constants for the infix integer expression evaluator
`timescale 1ns / 1ps

package ieval_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OUT_W      = 32;
    localparam int EXT_W      = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;

    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_DIGIT     = 4'd1,
        DP_START     = 4'd2,
        DP_TERM_CUR  = 4'd3,
        DP_TERM_UNIT = 4'd4,
        DP_PEND_MUL  = 4'd5,
        DP_PEND_DIV  = 4'd6,
        DP_SUM       = 4'd7,
        DP_EMIT      = 4'd8
    } t_dp_op;

    typedef struct packed {
        t_dp_op               op;
        logic [DIGIT_W-1:0]   digit;
        logic                 new_sub;
    } t_dp_cmd;

    typedef struct packed {
        logic pend_active;
        logic unit_done;
    } t_dp_status;

endpackage

/* hdl/infix_integer_expression_evaluator_core.sv */
// sequencing: a digit or ignored character is taken in ST_IDLE; * / + - go on
// through ST_POST, and through ST_CALC first when a * or / is pending (iterative
// muldiv unit, one bit per cycle; a divide by zero skips the bit steps)
// '=' also passes ST_EMIT, which waits until the output register is free
// throughput: one item at a time, sequenced by the controller
// reset: synchronous active-low i_rst_n clears the control and accumulator state and the output valid
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_core
    import ieval_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHAR_W-1:0]       i_char_code,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_value,
    output logic                    o_div_zero_error
);

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [OUT_W-1:0] w_value;

    ieval_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ieval_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_value          (w_value),
        .o_div_zero_error (o_div_zero_error)
    );

    assign o_value = signed'(w_value);

endmodule

/* hdl/ieval_muldiv.sv */
// iterative shift-add multiplier and restoring signed divider
`timescale 1ns / 1ps

module ieval_muldiv
    import ieval_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_is_div,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_div_zero
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_is_div;
    logic                  r_neg;
    logic                  r_dz;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;

    logic [DATA_WIDTH-1:0] w_ma;
    logic [DATA_WIDTH-1:0] w_mb;
    logic [DATA_WIDTH:0]   w_rem_sh;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_ge;

    assign w_ma     = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb     = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_rem_sh = {r_acc, r_x[DATA_WIDTH-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_y};
    assign w_ge     = ~w_diff[DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DATA_WIDTH - 1);
                if (i_is_div && (w_mb == '0)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_div <= i_is_div;
            r_acc    <= '0;
            if (i_is_div) begin
                r_neg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                r_dz  <= (w_mb == '0);
                r_x   <= (w_mb == '0) ? '0 : w_ma;
                r_y   <= w_mb;
            end else begin
                r_neg <= 1'b0;
                r_dz  <= 1'b0;
                r_x   <= i_a;
                r_y   <= i_b;
            end
        end else if (r_busy) begin
            if (r_is_div) begin
                r_acc <= w_ge ? w_diff[DATA_WIDTH-1:0] : w_rem_sh[DATA_WIDTH-1:0];
                r_x   <= {r_x[DATA_WIDTH-2:0], w_ge};
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[DATA_WIDTH-2:0], 1'b0};
                r_y <= {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
    end

    assign o_done     = r_done;
    assign o_div_zero = r_dz;
    assign o_result   = r_is_div ? (r_neg ? (~r_x + 1'b1) : r_x) : r_acc;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("muldiv done while busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && !r_done))
        else $error("muldiv started while in use");
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("muldiv did not finish after last step");
`endif

endmodule

/* hdl/ieval_dp.sv */
// datapath: number, term, sum and error registers with the muldiv unit
`timescale 1ns / 1ps

module ieval_dp
    import ieval_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic [OUT_W-1:0]   o_value,
    output logic               o_div_zero_error
);

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_MUL  = 2'd1;
    localparam logic [1:0] PEND_DIV  = 2'd2;

    logic [DATA_WIDTH-1:0] r_cur;
    logic [DATA_WIDTH-1:0] r_term;
    logic [1:0]            r_pend_op;
    logic [DATA_WIDTH-1:0] r_sum;
    logic                  r_pend_sub;
    logic                  r_err;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_err;

    logic                  w_unit_done;
    logic [DATA_WIDTH-1:0] w_unit_result;
    logic                  w_unit_dz;
    logic [DATA_WIDTH-1:0] w_cur_digit;
    logic [EXT_W-1:0]      w_out_ext;

    ieval_muldiv u_muldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == DP_START),
        .i_is_div   (r_pend_op == PEND_DIV),
        .i_a        (r_term),
        .i_b        (r_cur),
        .o_done     (w_unit_done),
        .o_result   (w_unit_result),
        .o_div_zero (w_unit_dz)
    );

    assign w_cur_digit = (r_cur << 3) + (r_cur << 1) + DATA_WIDTH'(i_cmd.digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_term     <= '0;
            r_pend_op  <= PEND_NONE;
            r_sum      <= '0;
            r_pend_sub <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_DIGIT: begin
                    r_cur <= w_cur_digit;
                end
                DP_TERM_CUR: begin
                    r_term <= r_cur;
                    r_cur  <= '0;
                end
                DP_TERM_UNIT: begin
                    r_term <= w_unit_result;
                    r_cur  <= '0;
                    r_err  <= r_err | w_unit_dz;
                end
                DP_PEND_MUL: begin
                    r_pend_op <= PEND_MUL;
                end
                DP_PEND_DIV: begin
                    r_pend_op <= PEND_DIV;
                end
                DP_SUM: begin
                    r_sum      <= r_pend_sub ? (r_sum - r_term) : (r_sum + r_term);
                    r_term     <= '0;
                    r_pend_op  <= PEND_NONE;
                    r_pend_sub <= i_cmd.new_sub;
                end
                DP_EMIT: begin
                    r_cur      <= '0;
                    r_term     <= '0;
                    r_pend_op  <= PEND_NONE;
                    r_sum      <= '0;
                    r_pend_sub <= 1'b0;
                    r_err      <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_EMIT) begin
            r_out_value <= r_sum;
            r_out_err   <= r_err;
        end
    end

    assign w_out_ext            = EXT_W'(r_out_value);
    assign o_value              = w_out_ext[OUT_W-1:0];
    assign o_div_zero_error     = r_out_err;
    assign o_status.pend_active = (r_pend_op == PEND_MUL) || (r_pend_op == PEND_DIV);
    assign o_status.unit_done   = w_unit_done;

endmodule

/* hdl/ieval_ctrl.sv */
// controller: character decode, sequencing state machine and output valid
`timescale 1ns / 1ps

module ieval_ctrl
    import ieval_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd
);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_POST = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        K_OTHER = 3'd0,
        K_DIGIT = 3'd1,
        K_MUL   = 3'd2,
        K_DIV   = 3'd3,
        K_ADD   = 3'd4,
        K_SUB   = 3'd5,
        K_EQ    = 3'd6
    } t_kind;

    t_state r_state;
    t_state n_state;
    t_kind  r_kind;
    t_kind  n_kind;
    t_kind  w_kind;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    always_comb begin
        if ((i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE)) begin
            w_kind = K_DIGIT;
        end else if (i_char_code == CH_MUL) begin
            w_kind = K_MUL;
        end else if (i_char_code == CH_DIV) begin
            w_kind = K_DIV;
        end else if (i_char_code == CH_ADD) begin
            w_kind = K_ADD;
        end else if (i_char_code == CH_SUB) begin
            w_kind = K_SUB;
        end else if (i_char_code == CH_EQ) begin
            w_kind = K_EQ;
        end else begin
            w_kind = K_OTHER;
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_out_valid   = r_out_valid;
        o_cmd.op      = DP_NOP;
        o_cmd.digit   = i_char_code[DIGIT_W-1:0];
        o_cmd.new_sub = 1'b0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_kind)
                        K_DIGIT: begin
                            o_cmd.op = DP_DIGIT;
                        end
                        K_MUL, K_DIV, K_ADD, K_SUB, K_EQ: begin
                            n_kind = w_kind;
                            if (i_status.pend_active) begin
                                o_cmd.op = DP_START;
                                n_state  = ST_CALC;
                            end else begin
                                o_cmd.op = DP_TERM_CUR;
                                n_state  = ST_POST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CALC: begin
                if (i_status.unit_done) begin
                    o_cmd.op = DP_TERM_UNIT;
                    n_state  = ST_POST;
                end
            end
            ST_POST: begin
                n_state = ST_IDLE;
                case (r_kind)
                    K_MUL: begin
                        o_cmd.op = DP_PEND_MUL;
                    end
                    K_DIV: begin
                        o_cmd.op = DP_PEND_DIV;
                    end
                    K_ADD: begin
                        o_cmd.op = DP_SUM;
                    end
                    K_SUB: begin
                        o_cmd.op      = DP_SUM;
                        o_cmd.new_sub = 1'b1;
                    end
                    K_EQ: begin
                        o_cmd.op = DP_SUM;
                        n_state  = ST_EMIT;
                    end
                    default: begin
                    end
                endcase
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = DP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= K_OTHER;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_calc_needs_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && n_state == ST_CALC) |-> i_status.pend_active)
        else $error("muldiv started with no pending operator");
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.unit_done |-> (r_state == ST_CALC))
        else $error("muldiv done outside calc state");
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_state == ST_IDLE) |=> o_valid)
        else $error("result item not presented after emit");
`endif

endmodule

/* tb/infix_integer_expression_evaluator_core_tb.sv */
// testbench for the infix integer expression evaluator core: random text stream, scoreboard check
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_core_tb;
    import ieval_pkg::*;

    localparam logic [CHAR_W-1:0] CH_ZERO  = "0";
    localparam logic [CHAR_W-1:0] CH_NINE  = "9";
    localparam logic [CHAR_W-1:0] CH_ADD   = "+";
    localparam logic [CHAR_W-1:0] CH_SUB   = "-";
    localparam logic [CHAR_W-1:0] CH_MUL   = "*";
    localparam logic [CHAR_W-1:0] CH_DIV   = "/";
    localparam logic [CHAR_W-1:0] CH_EQ    = "=";
    localparam logic [CHAR_W-1:0] CH_SPACE = " ";

    localparam int ITEM_TARGET = 1100;
    localparam int QUIET_FROM  = 950;
    localparam int PAUSE_AT    = 500;

    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_MUL  = 2'd1,
        TERM_DIV  = 2'd2
    } t_term_op;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    div_zero;
    } t_eval_result;

    class expr_scoreboard;
        logic [DATA_WIDTH-1:0] cur_num;
        logic [DATA_WIDTH-1:0] term_acc;
        logic [DATA_WIDTH-1:0] sum_acc;
        t_term_op              term_op;
        bit                    subtract_next;
        bit                    div0_seen;
        t_eval_result          pending_results[$];
        int unsigned           failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            cur_num       = '0;
            term_acc      = '0;
            sum_acc       = '0;
            term_op       = TERM_NONE;
            subtract_next = 1'b0;
            div0_seen     = 1'b0;
        endfunction

        // signed divide, truncating toward zero, with wrap
        function logic [DATA_WIDTH-1:0] quotient(input logic [DATA_WIDTH-1:0] a,
                                                 input logic [DATA_WIDTH-1:0] b);
            logic [DATA_WIDTH-1:0] mag_a;
            logic [DATA_WIDTH-1:0] mag_b;
            logic [DATA_WIDTH-1:0] q;
            mag_a = a[DATA_WIDTH-1] ? -a : a;
            mag_b = b[DATA_WIDTH-1] ? -b : b;
            if (mag_b == '0) begin
                div0_seen = 1'b1;
                return '0;
            end
            q = mag_a / mag_b;
            return (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -q : q;
        endfunction

        function void close_term();
            case (term_op)
                TERM_MUL: term_acc = term_acc * cur_num;
                TERM_DIV: term_acc = quotient(term_acc, cur_num);
                default:  term_acc = cur_num;
            endcase
            cur_num = '0;
        endfunction

        function void close_sum();
            sum_acc  = subtract_next ? sum_acc - term_acc : sum_acc + term_acc;
            term_acc = '0;
            term_op  = TERM_NONE;
        endfunction

        function void note_char(input logic [CHAR_W-1:0] ch);
            t_eval_result r;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                cur_num = cur_num * DATA_WIDTH'(10) + DATA_WIDTH'(ch - CH_ZERO);
            end else if (ch == CH_MUL || ch == CH_DIV) begin
                close_term();
                term_op = (ch == CH_MUL) ? TERM_MUL : TERM_DIV;
            end else if (ch == CH_ADD || ch == CH_SUB) begin
                close_term();
                close_sum();
                subtract_next = (ch == CH_SUB);
            end else if (ch == CH_EQ) begin
                close_term();
                close_sum();
                r.value    = sum_acc[OUT_W-1:0];
                r.div_zero = div0_seen;
                pending_results.push_back(r);
                clear();
            end
        endfunction

        function void check_result(input logic signed [OUT_W-1:0] value,
                                   input logic div_zero);
            t_eval_result want;
            if (pending_results.size() == 0) begin
                $error("result with no expression pending: value %0d, div_zero_error %0b",
                       value, div_zero);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, value);
                failures++;
            end
            if (div_zero !== want.div_zero) begin
                $error("div_zero_error: expected %0b, got %0b", want.div_zero, div_zero);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic [CHAR_W-1:0]       i_char_code = '0;
    logic                    i_stall     = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_value;
    logic                    o_div_zero_error;

    expr_scoreboard sb = new();
    int unsigned    items_sent = 0;
    int             idle_pct   = 0;
    bit             quiet      = 1'b0;
    bit             paused     = 1'b0;
    int             stall_left = 0;

    infix_integer_expression_evaluator_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_code      (i_char_code),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value          (o_value),
        .o_div_zero_error (o_div_zero_error)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_value, o_div_zero_error);
            end
            if (i_valid && !o_stall) begin
                sb.note_char(i_char_code);
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 9);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= ch;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_ADD || ch == CH_SUB
                || ch == CH_MUL || ch == CH_DIV || ch == CH_EQ) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic send_operand();
        int pick;
        int ndigits;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            ndigits = 0;
        end else if (pick == 1) begin
            send_char(CH_ZERO);
            ndigits = 0;
        end else if (pick <= 3) begin
            ndigits = $urandom_range(10, 11);
        end else begin
            ndigits = $urandom_range(1, 4);
        end
        for (int i = 0; i < ndigits; i++) begin
            send_char(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic send_expression();
        int n_terms;
        logic [CHAR_W-1:0] op;
        case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 40;
        endcase
        n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 5);
        if ($urandom_range(0, 7) == 0) begin
            send_char($urandom_range(0, 1) ? CH_SUB : CH_ADD);
        end
        for (int k = 0; k < n_terms; k++) begin
            if (k > 0) begin
                case ($urandom_range(0, 3))
                    0:       op = CH_ADD;
                    1:       op = CH_SUB;
                    2:       op = CH_MUL;
                    default: op = CH_DIV;
                endcase
                send_char(op);
            end
            if ($urandom_range(0, 5) == 0) begin
                send_char(CH_SPACE);
            end
            send_operand();
        end
        send_char(CH_EQ);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // most negative over minus one, digit wrap, missing operands, ignored bytes
        send_text("2147483648/4294967295=");
        send_char(8'h00);
        send_text("-99999999999+8*3/=");
        send_char(8'hFF);
        send_text(" =");

        while (items_sent < ITEM_TARGET) begin
            if (!paused && items_sent >= PAUSE_AT) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (sb.outstanding() != 0) @(negedge i_clk);
            end
            if (items_sent >= QUIET_FROM) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) send_char(CHAR_W'($urandom_range(0, 255)));
            end
            send_expression();
        end
        i_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("infix_integer_expression_evaluator_core_tb: PASS");
        end else begin
            $display("infix_integer_expression_evaluator_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("infix_integer_expression_evaluator_core_tb: FAIL");
        $finish;
    end

endmodule
